>>> hw/rtl/cba_pkg.sv
// Shared constants, codes and control types for the contiguous block allocator.
// No dependencies; the RTL files refer to this package by scoped names, the testbench imports it.
`timescale 1ns / 1ps

package cba_pkg;

    localparam int MAX_BLOCKS_DEF    = 64;
    localparam int MAX_BSIZE         = 4096;

    localparam int BSW               = 13;
    localparam int NBLK_W            = 7;
    localparam int BYTES_W           = 19;
    localparam int OFFSET_W          = 18;
    localparam int FREE_W            = 7;
    localparam int RSTART_W          = 6;
    localparam int RLEN_W            = 7;
    localparam int CFG_IDX_W         = 1;
    localparam int CFG_DATA_W        = 13;
    localparam int DVW               = 20;

    localparam int BSIZE_RST         = 64;
    localparam int BLOCKS_IN_USE_RST = 64;

    localparam logic [CFG_IDX_W-1:0] REG_BSIZE         = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_BLOCKS_IN_USE = 1'b1;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_NO_SPACE  = 2'd1,
        ST_NOT_START = 2'd2,
        ST_ZERO_SIZE = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DIV,
        S_FIT,
        S_MARK,
        S_RDLEN,
        S_CLEAR,
        S_STAT,
        S_PUB
    } t_state;

    typedef struct packed {
        logic    in_ready;
        logic    load;
        logic    div_start;
        logic    div_step;
        logic    scan_start;
        logic    fit_step;
        logic    free_prep;
        logic    sweep_step;
        logic    commit_alloc;
        logic    commit_free;
        logic    stat_step;
        logic    set_status;
        t_status status;
        logic    publish;
    } t_cmd;

    typedef struct packed {
        logic in_valid;
        logic zero_req;
        logic div_done;
        logic is_free;
        logic free_ok;
        logic fit_end;
        logic fit_hit;
        logic sweep_end;
        logic stat_end;
        logic out_free;
    } t_sts;

endpackage

>>> hw/rtl/cba_if.sv
// Valid/ready channels for requests and results of the block allocator.
// Depends on cba_pkg for field widths.
`timescale 1ns / 1ps

interface cba_req_if;
    logic                          valid;
    logic                          ready;
    logic                          action;
    logic [cba_pkg::BYTES_W-1:0]   request_bytes;
    logic [cba_pkg::OFFSET_W-1:0]  release_offset;

    modport source (output valid, action, request_bytes, release_offset, input ready);
    modport sink   (input valid, action, request_bytes, release_offset, output ready);
endinterface

interface cba_rsp_if;
    logic                          valid;
    logic                          ready;
    logic [1:0]                    status;
    logic [cba_pkg::OFFSET_W-1:0]  block_offset;
    logic [cba_pkg::FREE_W-1:0]    free_blocks;
    logic [cba_pkg::RSTART_W-1:0]  largest_run_start;
    logic [cba_pkg::RLEN_W-1:0]    largest_run_length;

    modport source (output valid, status, block_offset, free_blocks, largest_run_start,
                    largest_run_length, input ready);
    modport sink   (input valid, status, block_offset, free_blocks, largest_run_start,
                    largest_run_length, output ready);
endinterface

>>> hw/rtl/cba_ctrl.sv
// Controller state machine of the block allocator: sequences divide, scans and sweeps.
// Depends on cba_pkg for the state, command and status types.
`timescale 1ns / 1ps

module cba_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  cba_pkg::t_sts i_sts,
    output cba_pkg::t_cmd o_cmd
);

    cba_pkg::t_state r_state;
    cba_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= cba_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state      = r_state;
        o_cmd        = '0;
        o_cmd.status = cba_pkg::ST_OK;
        case (r_state)
            cba_pkg::S_IDLE: begin
                o_cmd.in_ready = 1'b1;
                if (i_sts.in_valid) begin
                    o_cmd.load = 1'b1;
                    if (i_sts.zero_req) begin
                        o_cmd.scan_start = 1'b1;
                        n_state          = cba_pkg::S_STAT;
                    end else begin
                        o_cmd.div_start = 1'b1;
                        n_state         = cba_pkg::S_DIV;
                    end
                end
            end
            cba_pkg::S_DIV: begin
                if (!i_sts.div_done) begin
                    o_cmd.div_step = 1'b1;
                end else if (!i_sts.is_free) begin
                    o_cmd.scan_start = 1'b1;
                    n_state          = cba_pkg::S_FIT;
                end else if (i_sts.free_ok) begin
                    o_cmd.free_prep = 1'b1;
                    n_state         = cba_pkg::S_RDLEN;
                end else begin
                    o_cmd.set_status = 1'b1;
                    o_cmd.status     = cba_pkg::ST_NOT_START;
                    o_cmd.scan_start = 1'b1;
                    n_state          = cba_pkg::S_STAT;
                end
            end
            cba_pkg::S_FIT: begin
                if (i_sts.fit_end) begin
                    o_cmd.set_status = 1'b1;
                    o_cmd.status     = cba_pkg::ST_NO_SPACE;
                    o_cmd.scan_start = 1'b1;
                    n_state          = cba_pkg::S_STAT;
                end else begin
                    o_cmd.fit_step = 1'b1;
                    if (i_sts.fit_hit) begin
                        n_state = cba_pkg::S_MARK;
                    end
                end
            end
            cba_pkg::S_MARK: begin
                if (i_sts.sweep_end) begin
                    o_cmd.commit_alloc = 1'b1;
                    o_cmd.scan_start   = 1'b1;
                    n_state            = cba_pkg::S_STAT;
                end else begin
                    o_cmd.sweep_step = 1'b1;
                end
            end
            cba_pkg::S_RDLEN: begin
                n_state = cba_pkg::S_CLEAR;
            end
            cba_pkg::S_CLEAR: begin
                if (i_sts.sweep_end) begin
                    o_cmd.commit_free = 1'b1;
                    o_cmd.scan_start  = 1'b1;
                    n_state           = cba_pkg::S_STAT;
                end else begin
                    o_cmd.sweep_step = 1'b1;
                end
            end
            cba_pkg::S_STAT: begin
                if (i_sts.stat_end) begin
                    n_state = cba_pkg::S_PUB;
                end else begin
                    o_cmd.stat_step = 1'b1;
                end
            end
            cba_pkg::S_PUB: begin
                if (i_sts.out_free) begin
                    o_cmd.publish = 1'b1;
                    n_state       = cba_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = cba_pkg::S_IDLE;
            end
        endcase
    end

endmodule

>>> hw/rtl/cba_dp.sv
// Datapath of the block allocator: configuration, used map, length memory,
// serial divider, scan counters and result register. Depends on cba_pkg and cba_if.
`timescale 1ns / 1ps

module cba_dp #(
    parameter int MAX_BLOCKS = cba_pkg::MAX_BLOCKS_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [cba_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [cba_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    input  cba_pkg::t_cmd                    i_cmd,
    output cba_pkg::t_sts                    o_sts,
    cba_req_if.sink                          i_req,
    cba_rsp_if.source                        o_rsp
);

    localparam int IW  = $clog2(MAX_BLOCKS);
    localparam int CW  = $clog2(MAX_BLOCKS + 1);
    localparam int BSW = cba_pkg::BSW;
    localparam int DVW = cba_pkg::DVW;
    localparam int DCW = $clog2(DVW + 1);
    localparam int PW  = IW + BSW;

    logic [BSW-1:0]                    r_bsize;
    logic [cba_pkg::NBLK_W-1:0]        r_nblk;
    logic [MAX_BLOCKS-1:0]             r_used;
    logic [MAX_BLOCKS-1:0]             r_valid;
    logic                              r_ovalid;

    logic                              r_action;
    cba_pkg::t_status                  r_status;
    logic [cba_pkg::OFFSET_W-1:0]      r_granted;
    logic [BSW-1:0]                    r_rem;
    logic [DVW-1:0]                    r_quo;
    logic [DCW-1:0]                    r_dcnt;
    logic [CW-1:0]                     r_idx;
    logic [CW-1:0]                     r_run;
    logic [CW-1:0]                     r_best;
    logic [CW-1:0]                     r_free;
    logic [IW-1:0]                     r_where;
    logic [IW-1:0]                     r_start;
    logic [CW-1:0]                     r_ptr;
    logic [CW-1:0]                     r_cnt;
    logic [CW-1:0]                     r_len;
    logic [CW-1:0]                     r_alen [MAX_BLOCKS];
    logic [CW-1:0]                     r_alen_q;

    cba_pkg::t_status                  r_ostatus;
    logic [cba_pkg::OFFSET_W-1:0]      r_ooffset;
    logic [cba_pkg::FREE_W-1:0]        r_ofree;
    logic [cba_pkg::RSTART_W-1:0]      r_ostart;
    logic [cba_pkg::RLEN_W-1:0]        r_olen;

    logic [BSW-1:0]                    w_bs;
    logic [CW-1:0]                     w_n;
    logic [BSW:0]                      w_trial;
    logic [BSW:0]                      w_sub;
    logic                              w_ge;
    logic                              w_cur_used;
    logic                              w_in_range;
    logic [CW-1:0]                     w_run_inc;
    logic [CW-1:0]                     w_run_begin;
    logic                              w_fit_hit;
    logic [CW-1:0]                     w_sweep_len;
    logic                              w_sweep_end;
    logic                              w_free_ok;
    logic                              w_zero_req;
    logic [DVW-1:0]                    w_dividend;
    logic [PW-1:0]                     w_prod;
    logic                              w_out_free;

    always_comb begin
        if (r_bsize == '0) begin
            w_bs = BSW'(1);
        end else if (int'(r_bsize) > cba_pkg::MAX_BSIZE) begin
            w_bs = BSW'(cba_pkg::MAX_BSIZE);
        end else begin
            w_bs = r_bsize;
        end
        if (r_nblk == '0) begin
            w_n = CW'(1);
        end else if (int'(r_nblk) > MAX_BLOCKS) begin
            w_n = CW'(MAX_BLOCKS);
        end else begin
            w_n = CW'(r_nblk);
        end
    end

    assign w_trial     = {r_rem, r_quo[DVW-1]};
    assign w_ge        = (w_trial >= {1'b0, w_bs});
    assign w_sub       = w_trial - {1'b0, w_bs};
    assign w_in_range  = (r_idx < w_n);
    assign w_cur_used  = r_used[r_idx[IW-1:0]];
    assign w_run_inc   = r_run + CW'(1);
    assign w_run_begin = r_idx - r_run;
    assign w_fit_hit   = w_in_range && !w_cur_used && (DVW'(w_run_inc) == r_quo);
    assign w_sweep_len = r_action ? r_alen_q : r_len;
    assign w_sweep_end = !((r_cnt < w_sweep_len) && (r_ptr < CW'(MAX_BLOCKS)));
    assign w_free_ok   = (r_quo < DVW'(w_n)) && r_valid[r_quo[IW-1:0]];
    assign w_zero_req  = !i_req.action && (i_req.request_bytes == '0);
    assign w_dividend  = i_req.action ? DVW'(i_req.release_offset)
                                      : DVW'(i_req.request_bytes) + DVW'(w_bs) - DVW'(1);
    assign w_prod      = PW'(r_start) * PW'(w_bs);
    assign w_out_free  = !r_ovalid || o_rsp.ready;

    assign o_sts.in_valid  = i_req.valid;
    assign o_sts.zero_req  = w_zero_req;
    assign o_sts.div_done  = (r_dcnt == DCW'(DVW));
    assign o_sts.is_free   = r_action;
    assign o_sts.free_ok   = w_free_ok;
    assign o_sts.fit_end   = !w_in_range;
    assign o_sts.fit_hit   = w_fit_hit;
    assign o_sts.sweep_end = w_sweep_end;
    assign o_sts.stat_end  = !w_in_range;
    assign o_sts.out_free  = w_out_free;

    assign i_req.ready              = i_cmd.in_ready;
    assign o_rsp.valid              = r_ovalid;
    assign o_rsp.status             = r_ostatus;
    assign o_rsp.block_offset       = r_ooffset;
    assign o_rsp.free_blocks        = r_ofree;
    assign o_rsp.largest_run_start  = r_ostart;
    assign o_rsp.largest_run_length = r_olen;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bsize  <= BSW'(cba_pkg::BSIZE_RST);
            r_nblk   <= cba_pkg::NBLK_W'(cba_pkg::BLOCKS_IN_USE_RST);
            r_used   <= '0;
            r_valid  <= '0;
            r_ovalid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    cba_pkg::REG_BSIZE: begin
                        r_bsize <= i_cfg_data[BSW-1:0];
                    end
                    cba_pkg::REG_BLOCKS_IN_USE: begin
                        r_nblk <= i_cfg_data[cba_pkg::NBLK_W-1:0];
                    end
                    default: begin
                    end
                endcase
            end
            if (i_cmd.sweep_step) begin
                r_used[r_ptr[IW-1:0]] <= !r_action;
            end
            if (i_cmd.commit_alloc) begin
                r_valid[r_start] <= 1'b1;
            end
            if (i_cmd.commit_free) begin
                r_valid[r_start] <= 1'b0;
            end
            if (i_cmd.publish) begin
                r_ovalid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_action  <= i_req.action;
            r_status  <= w_zero_req ? cba_pkg::ST_ZERO_SIZE : cba_pkg::ST_OK;
            r_granted <= '0;
        end
        if (i_cmd.set_status) begin
            r_status <= i_cmd.status;
        end
        if (i_cmd.div_start) begin
            r_rem  <= '0;
            r_quo  <= w_dividend;
            r_dcnt <= '0;
        end else if (i_cmd.div_step) begin
            r_rem  <= w_ge ? w_sub[BSW-1:0] : w_trial[BSW-1:0];
            r_quo  <= {r_quo[DVW-2:0], w_ge};
            r_dcnt <= r_dcnt + DCW'(1);
        end
        if (i_cmd.scan_start) begin
            r_idx   <= '0;
            r_run   <= '0;
            r_best  <= '0;
            r_free  <= '0;
            r_where <= '0;
        end else if (i_cmd.fit_step) begin
            if (w_fit_hit) begin
                r_start <= w_run_begin[IW-1:0];
                r_ptr   <= w_run_begin;
                r_cnt   <= '0;
                r_len   <= w_run_inc;
            end else begin
                r_run <= w_cur_used ? '0 : w_run_inc;
                r_idx <= r_idx + CW'(1);
            end
        end else if (i_cmd.stat_step) begin
            if (!w_cur_used) begin
                r_run  <= w_run_inc;
                r_free <= r_free + CW'(1);
                if (w_run_inc > r_best) begin
                    r_best  <= w_run_inc;
                    r_where <= w_run_begin[IW-1:0];
                end
            end else begin
                r_run <= '0;
            end
            r_idx <= r_idx + CW'(1);
        end
        if (i_cmd.free_prep) begin
            r_start <= r_quo[IW-1:0];
            r_ptr   <= CW'(r_quo[IW-1:0]);
            r_cnt   <= '0;
        end
        if (i_cmd.sweep_step) begin
            r_ptr <= r_ptr + CW'(1);
            r_cnt <= r_cnt + CW'(1);
        end
        if (i_cmd.commit_alloc) begin
            r_granted <= cba_pkg::OFFSET_W'(w_prod);
        end
        if (i_cmd.publish) begin
            r_ostatus <= r_status;
            r_ooffset <= r_granted;
            r_ofree   <= cba_pkg::FREE_W'(r_free);
            r_ostart  <= cba_pkg::RSTART_W'(r_where);
            r_olen    <= cba_pkg::RLEN_W'(r_best);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.commit_alloc) begin
            r_alen[r_start] <= r_len;
        end
        r_alen_q <= r_alen[r_start];
    end

endmodule

>>> hw/rtl/contiguous_block_allocator_unit.sv
// One item at a time: an allocate runs the serial divider, then one-block-per-cycle passes over
// the used map (search, sweep, statistics); a free runs the divider, a clearing sweep and the
// statistics pass; a zero-size request skips the divider and runs only the statistics pass.
// The next item is taken while the previous result still waits in the result register.
// Synchronous active-low reset clears the used map and allocation marks at once,
// loads block size 64 and blocks_in_use 64; no clearing pass is needed.
`timescale 1ns / 1ps

module contiguous_block_allocator_unit #(
    parameter int MAX_BLOCKS = cba_pkg::MAX_BLOCKS_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [cba_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [cba_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    cba_req_if.sink                          i_req,
    cba_rsp_if.source                        o_rsp
);

    cba_pkg::t_cmd w_cmd;
    cba_pkg::t_sts w_sts;

    cba_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_sts   (w_sts),
        .o_cmd   (w_cmd)
    );

    cba_dp #(
        .MAX_BLOCKS (MAX_BLOCKS)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_cmd      (w_cmd),
        .o_sts      (w_sts),
        .i_req      (i_req),
        .o_rsp      (o_rsp)
    );

endmodule

>>> hw/rtl/cba_checker.sv
// Port-level checks of the block allocator, bound to the top level.
// Depends on cba_pkg and on contiguous_block_allocator_unit.
`timescale 1ns / 1ps

module cba_checker (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            i_req_valid,
    input logic                            i_req_ready,
    input logic                            i_rsp_valid,
    input logic                            i_rsp_ready,
    input logic [1:0]                      i_status,
    input logic [cba_pkg::OFFSET_W-1:0]    i_block_offset,
    input logic [cba_pkg::FREE_W-1:0]      i_free_blocks,
    input logic [cba_pkg::RSTART_W-1:0]    i_run_start,
    input logic [cba_pkg::RLEN_W-1:0]      i_run_length
);

    a_run_within_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid |-> (i_run_length <= i_free_blocks))
        else $error("largest run exceeds free block count");

    a_offset_only_on_grant: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rsp_valid && (i_status != cba_pkg::ST_OK)) |-> (i_block_offset == '0))
        else $error("offset reported for a transaction that was not granted");

    a_empty_run_at_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rsp_valid && (i_run_length == '0)) |-> (i_run_start == '0))
        else $error("empty largest run with non-zero start");

    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_req_valid && i_req_ready) |=> !i_req_ready)
        else $error("request taken while previous transaction in progress");

    a_rsp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_rst_n) && $past(i_rsp_valid && !i_rsp_ready)) |->
            (i_rsp_valid && $stable(i_status) && $stable(i_block_offset)
             && $stable(i_free_blocks) && $stable(i_run_start) && $stable(i_run_length)))
        else $error("stalled result changed");

endmodule

bind contiguous_block_allocator_unit cba_checker u_cba_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_req_valid    (i_req.valid),
    .i_req_ready    (i_req.ready),
    .i_rsp_valid    (o_rsp.valid),
    .i_rsp_ready    (o_rsp.ready),
    .i_status       (o_rsp.status),
    .i_block_offset (o_rsp.block_offset),
    .i_free_blocks  (o_rsp.free_blocks),
    .i_run_start    (o_rsp.largest_run_start),
    .i_run_length   (o_rsp.largest_run_length)
);

>>> dv/contiguous_block_allocator_unit_test.sv
// Self-checking testbench for contiguous_block_allocator_unit: directed and random
// alloc/free transactions over several pool settings, checked against a built-in predictor.
// Depends on cba_pkg, cba_if.sv and the allocator RTL.
`timescale 1ns / 1ps

module contiguous_block_allocator_unit_test;

    import cba_pkg::*;

    localparam logic ACT_ALLOC = 1'b0;
    localparam logic ACT_FREE  = 1'b1;
    localparam int   CYCLE_LIMIT = 5000000;

    typedef struct {
        logic                action;
        logic [BYTES_W-1:0]  bytes;
        logic [OFFSET_W-1:0] offset;
    } alloc_req_t;

    typedef struct {
        t_status             status;
        logic [OFFSET_W-1:0] block_offset;
        logic [FREE_W-1:0]   free_blocks;
        logic [RSTART_W-1:0] run_start;
        logic [RLEN_W-1:0]   run_len;
    } alloc_result_t;

    logic i_clk = 1'b0;
    logic i_rst_n;
    logic i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    cba_req_if req_ch ();
    cba_rsp_if rsp_ch ();

    contiguous_block_allocator_unit uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_req      (req_ch),
        .o_rsp      (rsp_ch)
    );

    always #5 i_clk = ~i_clk;

    // allocator shadow state
    bit          pool_used [MAX_BLOCKS_DEF];
    int unsigned alloc_len [MAX_BLOCKS_DEF];
    int unsigned best_start;
    int unsigned best_len;
    int unsigned cfg_bsize;
    int unsigned cfg_pool_blocks;

    alloc_req_t    request_queue [$];
    alloc_result_t awaited_results [$];

    int unsigned error_count;
    int unsigned cycle_count;
    int unsigned accepted_count;
    int unsigned settings_count;
    int unsigned status_seen [4];
    int unsigned choke_cycles;
    bit          steady_flow;

    function automatic int unsigned eff_block_bytes();
        if (cfg_bsize == 0) return 1;
        if (cfg_bsize > MAX_BSIZE) return MAX_BSIZE;
        return cfg_bsize;
    endfunction

    function automatic int unsigned eff_pool_blocks();
        if (cfg_pool_blocks == 0) return 1;
        if (cfg_pool_blocks > MAX_BLOCKS_DEF) return MAX_BLOCKS_DEF;
        return cfg_pool_blocks;
    endfunction

    function automatic void rescan_runs();
        int unsigned n;
        int unsigned run;
        n = eff_pool_blocks();
        run = 0;
        best_start = 0;
        best_len = 0;
        for (int i = 0; i < n; i++) begin
            if (!pool_used[i]) begin
                run++;
                if (run > best_len) begin
                    best_len = run;
                    best_start = i + 1 - run;
                end
            end else begin
                run = 0;
            end
        end
    endfunction

    function automatic void predict_allocator(logic action, logic [BYTES_W-1:0] bytes,
                                              logic [OFFSET_W-1:0] offset);
        int unsigned   bs;
        int unsigned   n;
        int unsigned   need;
        int unsigned   run;
        int unsigned   start;
        int unsigned   idx;
        int unsigned   len;
        int unsigned   free_cnt;
        bit            found;
        alloc_result_t res;
        bs = eff_block_bytes();
        n = eff_pool_blocks();
        res.status = ST_OK;
        res.block_offset = '0;
        found = 1'b0;
        run = 0;
        start = 0;
        if (action == ACT_ALLOC) begin
            if (bytes == 0) begin
                res.status = ST_ZERO_SIZE;
            end else begin
                need = (int'(bytes) + bs - 1) / bs;
                if (need <= best_len) begin
                    for (int i = 0; i < n && !found; i++) begin
                        if (!pool_used[i]) begin
                            run++;
                            if (run == need) begin
                                start = i + 1 - need;
                                found = 1'b1;
                            end
                        end else begin
                            run = 0;
                        end
                    end
                end
                if (!found) begin
                    res.status = ST_NO_SPACE;
                end else begin
                    for (int i = start; i < start + need; i++) pool_used[i] = 1'b1;
                    alloc_len[start] = need;
                    res.block_offset = OFFSET_W'(start * bs);
                end
            end
        end else begin
            idx = offset / bs;
            if (idx >= n || alloc_len[idx] == 0) begin
                res.status = ST_NOT_START;
            end else begin
                len = alloc_len[idx];
                for (int i = idx; i < idx + len && i < MAX_BLOCKS_DEF; i++) pool_used[i] = 1'b0;
                alloc_len[idx] = 0;
            end
        end
        rescan_runs();
        free_cnt = 0;
        for (int i = 0; i < n; i++) if (!pool_used[i]) free_cnt++;
        res.free_blocks = FREE_W'(free_cnt);
        res.run_start = RSTART_W'(best_start);
        res.run_len = RLEN_W'(best_len);
        awaited_results.push_back(res);
    endfunction

    task automatic flag_mismatch(string what);
        error_count++;
        $display("[%0t] mismatch: %s", $time, what);
    endtask

    // request driver
    int unsigned gap_left;
    alloc_req_t  next_req;

    function automatic int unsigned draw_idle();
        int unsigned r;
        if (steady_flow) return 0;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(4, 40);
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            req_ch.valid <= 1'b0;
            gap_left = 0;
        end else begin
            if (req_ch.valid && req_ch.ready) begin
                predict_allocator(req_ch.action, req_ch.request_bytes, req_ch.release_offset);
                accepted_count++;
            end
            if (!req_ch.valid || req_ch.ready) begin
                if (gap_left > 0) begin
                    gap_left--;
                    req_ch.valid <= 1'b0;
                end else if (request_queue.size() > 0) begin
                    next_req = request_queue.pop_front();
                    req_ch.valid          <= 1'b1;
                    req_ch.action         <= next_req.action;
                    req_ch.request_bytes  <= next_req.bytes;
                    req_ch.release_offset <= next_req.offset;
                    gap_left = draw_idle();
                end else begin
                    req_ch.valid <= 1'b0;
                end
            end
        end
    end

    // result monitor
    int unsigned   stall_left;
    alloc_result_t want;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            rsp_ch.ready <= 1'b0;
            stall_left = 0;
        end else begin
            if (rsp_ch.valid && rsp_ch.ready) begin
                if (awaited_results.size() == 0) begin
                    flag_mismatch($sformatf("unexpected result, status %0d offset %0d",
                                            rsp_ch.status, rsp_ch.block_offset));
                end else begin
                    want = awaited_results.pop_front();
                    status_seen[want.status]++;
                    if (rsp_ch.status !== want.status)
                        flag_mismatch($sformatf("status %0d, want %s",
                                                rsp_ch.status, want.status.name()));
                    if (rsp_ch.block_offset !== want.block_offset)
                        flag_mismatch($sformatf("block_offset %0d, want %0d",
                                                rsp_ch.block_offset, want.block_offset));
                    if (rsp_ch.free_blocks !== want.free_blocks)
                        flag_mismatch($sformatf("free_blocks %0d, want %0d",
                                                rsp_ch.free_blocks, want.free_blocks));
                    if (rsp_ch.largest_run_start !== want.run_start)
                        flag_mismatch($sformatf("largest_run_start %0d, want %0d",
                                                rsp_ch.largest_run_start, want.run_start));
                    if (rsp_ch.largest_run_length !== want.run_len)
                        flag_mismatch($sformatf("largest_run_length %0d, want %0d",
                                                rsp_ch.largest_run_length, want.run_len));
                end
            end
            if (choke_cycles > 0) begin
                stall_left = choke_cycles;
                choke_cycles = 0;
            end
            if (stall_left > 0) begin
                stall_left--;
                rsp_ch.ready <= 1'b0;
            end else begin
                rsp_ch.ready <= 1'b1;
                stall_left = draw_idle();
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, awaited_results.size());
            $display("contiguous_block_allocator_unit_test: FAIL");
            $finish;
        end
    end

    function automatic void queue_request(logic action, int unsigned bytes, int unsigned offset);
        alloc_req_t r;
        r.action = action;
        r.bytes = BYTES_W'(bytes);
        r.offset = OFFSET_W'(offset);
        request_queue.push_back(r);
    endfunction

    task automatic drain_all();
        do @(negedge i_clk);
        while (request_queue.size() != 0 || req_ch.valid || awaited_results.size() != 0);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == REG_BSIZE) begin
            cfg_bsize = data;
        end else begin
            cfg_pool_blocks = data[NBLK_W-1:0];
            rescan_runs();
        end
    endtask

    task automatic set_pool(int unsigned bs_val, int unsigned n_val);
        drain_all();
        write_reg(REG_BSIZE, CFG_DATA_W'(bs_val));
        write_reg(REG_BLOCKS_IN_USE, CFG_DATA_W'(n_val));
        settings_count++;
        @(negedge i_clk);
    endtask

    // mostly well-formed traffic: allocs sized in blocks, frees of live starts
    task automatic make_batch(int unsigned count);
        int unsigned live [$];
        int unsigned bs;
        int unsigned n;
        int unsigned need;
        int unsigned pick;
        int unsigned start;
        int unsigned r;
        bs = eff_block_bytes();
        n = eff_pool_blocks();
        for (int i = 0; i < n; i++) if (alloc_len[i] != 0) live.push_back(i);
        for (int k = 0; k < count; k++) begin
            r = $urandom_range(0, 99);
            if (r >= 50 && r < 85 && live.size() > 0) begin
                pick = $urandom_range(0, live.size() - 1);
                start = live[pick];
                live.delete(pick);
                queue_request(ACT_FREE, $urandom, start * bs + $urandom_range(0, bs - 1));
            end else if (r >= 85 && r < 92) begin
                queue_request(ACT_ALLOC, ($urandom_range(0, 3) == 0) ? 0 :
                              $urandom_range(0, 262144), $urandom);
            end else if (r >= 92) begin
                queue_request(ACT_FREE, $urandom, $urandom_range(0, 262143));
            end else begin
                if ($urandom_range(0, 3) == 0) need = $urandom_range(1, n);
                else need = $urandom_range(1, (n + 3) / 4);
                queue_request(ACT_ALLOC, (need - 1) * bs + $urandom_range(1, bs), $urandom);
            end
        end
    endtask

    task automatic run_random(int unsigned count);
        int unsigned sent;
        sent = 0;
        while (sent < count) begin
            make_batch(16);
            sent += 16;
            drain_all();
        end
    endtask

    initial begin
        i_rst_n    = 1'b0;
        i_cfg_we   = 1'b0;
        i_cfg_idx  = '0;
        i_cfg_data = '0;
        req_ch.valid          = 1'b0;
        req_ch.action         = ACT_ALLOC;
        req_ch.request_bytes  = '0;
        req_ch.release_offset = '0;
        rsp_ch.ready          = 1'b0;
        for (int i = 0; i < MAX_BLOCKS_DEF; i++) begin
            pool_used[i] = 1'b0;
            alloc_len[i] = 0;
        end
        cfg_bsize       = BSIZE_RST;
        cfg_pool_blocks = BLOCKS_IN_USE_RST;
        rescan_runs();
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // reset settings: rounding, fit, bad frees, fill and empty
        queue_request(ACT_ALLOC, 0, 0);
        queue_request(ACT_ALLOC, 1, 0);
        queue_request(ACT_ALLOC, 64, 0);
        queue_request(ACT_ALLOC, 65, 0);
        queue_request(ACT_FREE, 0, 127);
        queue_request(ACT_FREE, 0, 64);
        queue_request(ACT_FREE, 0, 192);
        queue_request(ACT_FREE, 0, 262143);
        queue_request(ACT_ALLOC, 262144, 0);
        queue_request(ACT_ALLOC, 3840, 0);
        queue_request(ACT_ALLOC, 64, 0);
        queue_request(ACT_ALLOC, 1, 0);
        queue_request(ACT_FREE, 0, 0);
        queue_request(ACT_FREE, 0, 128);
        queue_request(ACT_FREE, 0, 256);
        queue_request(ACT_FREE, 0, 64);
        drain_all();

        // fill the block and stall its input behind a held-off receiver
        steady_flow = 1'b1;
        choke_cycles = 3000;
        make_batch(12);
        drain_all();
        steady_flow = 1'b0;

        // zero block size and zero pool size
        set_pool(0, 0);
        queue_request(ACT_ALLOC, 1, 0);
        queue_request(ACT_ALLOC, 1, 0);
        queue_request(ACT_FREE, 0, 1);
        queue_request(ACT_FREE, 0, 0);
        drain_all();
        run_random(150);

        // oversize settings, then shrink the pool under live allocations
        set_pool(8191, 127);
        queue_request(ACT_ALLOC, 262144, 0);
        queue_request(ACT_FREE, 0, 4095);
        queue_request(ACT_ALLOC, 40960, 0);
        queue_request(ACT_ALLOC, 163840, 0);
        set_pool(8191, 20);
        queue_request(ACT_FREE, 0, 40960);
        queue_request(ACT_ALLOC, 163840, 0);
        queue_request(ACT_FREE, 0, 0);
        run_random(150);
        set_pool(8191, 127);
        run_random(250);

        set_pool(1, 8);
        run_random(300);
        steady_flow = 1'b1;
        set_pool(100, 16);
        run_random(300);
        steady_flow = 1'b0;
        set_pool(37, 33);
        run_random(300);
        set_pool(4096, 64);
        run_random(250);
        set_pool(512, 5);
        run_random(300);
        set_pool(3, 64);
        run_random(150);

        drain_all();
        repeat (250) @(negedge i_clk);

        $display("%0d transactions checked over %0d pool settings plus the reset one",
                 accepted_count, settings_count);
        $display("granted %0d, no space %0d, bad free %0d, zero size %0d",
                 status_seen[ST_OK], status_seen[ST_NO_SPACE],
                 status_seen[ST_NOT_START], status_seen[ST_ZERO_SIZE]);
        if (error_count == 0 && awaited_results.size() == 0) begin
            $display("contiguous_block_allocator_unit_test: PASS");
        end else begin
            $display("contiguous_block_allocator_unit_test: FAIL");
        end
        $finish;
    end

endmodule

>>> filelist.f
hw/rtl/cba_pkg.sv
hw/rtl/cba_if.sv
hw/rtl/cba_ctrl.sv
hw/rtl/cba_dp.sv
hw/rtl/contiguous_block_allocator_unit.sv
hw/rtl/cba_checker.sv
dv/contiguous_block_allocator_unit_test.sv
